>>> src/uoas_pkg.sv
`default_nettype none

package uoas_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TIMER_BITS = 24;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    // Configuration register indexes
    localparam logic [2:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ECHO_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_STOP_TIME      = 3'd2;
    localparam logic [2:0] REG_REVERSE_TIME   = 3'd3;
    localparam logic [2:0] REG_TURN_TIME      = 3'd4;
    localparam logic [2:0] REG_SETTLE_TIME    = 3'd5;
    localparam logic [2:0] REG_FAST_DUTY      = 3'd6;
    localparam logic [2:0] REG_SLOW_DUTY      = 3'd7;

    // Motor modes
    localparam logic [2:0] MODE_STOP        = 3'd0;
    localparam logic [2:0] MODE_FORWARD     = 3'd1;
    localparam logic [2:0] MODE_REVERSE     = 3'd2;
    localparam logic [2:0] MODE_QUICK_LEFT  = 3'd3;
    localparam logic [2:0] MODE_SOFT_LEFT   = 3'd4;
    localparam logic [2:0] MODE_QUICK_RIGHT = 3'd5;
    localparam logic [2:0] MODE_SOFT_RIGHT  = 3'd6;
    localparam logic [2:0] MODE_NONE        = 3'd7;

    // Bridge pin patterns
    localparam logic [3:0] PINS_RESET   = 4'b0000;
    localparam logic [3:0] PINS_BRAKE   = 4'b1111;
    localparam logic [3:0] PINS_FORWARD = 4'b0101;
    localparam logic [3:0] PINS_REVERSE = 4'b1010;
    localparam logic [3:0] PINS_SPIN_L  = 4'b0110;
    localparam logic [3:0] PINS_SPIN_R  = 4'b1001;

    localparam logic [9:0] DUTY_MAX   = 10'd999;
    localparam logic [9:0] DUTY_RESET = 10'd333;

    typedef struct packed {
        logic [15:0] near_threshold;
        logic [15:0] echo_timeout;
        logic [23:0] stop_time;
        logic [23:0] reverse_time;
        logic [23:0] turn_time;
        logic [23:0] settle_time;
        logic [9:0]  fast_duty;
        logic [9:0]  slow_duty;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COUNT_BITS-1:0] counts;   // index 0 front, 1 right, 2 left
        logic [2:0]                 invalid;
    } echo_stat_t;

    typedef struct packed {
        logic [3:0] pins;
        logic [9:0] duty_a;
        logic [9:0] duty_b;
        logic [2:0] mode;
    } drive_t;

    function automatic logic [9:0] duty_sat(input logic [9:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

    function automatic logic [TIMER_BITS-1:0] timer_sat(input logic [23:0] d);
        logic [47:0] tmax;
        logic [47:0] ext;
        tmax = (48'd1 << TIMER_BITS) - 48'd1;
        ext  = 48'(d);
        return (ext > tmax) ? TIMER_BITS'(tmax) : TIMER_BITS'(ext);
    endfunction

    function automatic logic [15:0] count_disp(input logic [COUNT_BITS-1:0] c);
        return (c > COUNT_BITS'(32'h0000_FFFF)) ? 16'hFFFF : 16'(c);
    endfunction

    // Stop keeps the current duties; all other modes load them.
    function automatic drive_t apply_mode(input drive_t cur, input logic [2:0] m,
                                          input logic [9:0] fast, input logic [9:0] slow);
        drive_t     d;
        logic [9:0] f;
        logic [9:0] s;
        f      = duty_sat(fast);
        s      = duty_sat(slow);
        d      = cur;
        d.mode = m;
        case (m)
            MODE_STOP:        d.pins = PINS_BRAKE;
            MODE_FORWARD:     begin d.pins = PINS_FORWARD; d.duty_a = f; d.duty_b = f; end
            MODE_REVERSE:     begin d.pins = PINS_REVERSE; d.duty_a = f; d.duty_b = f; end
            MODE_QUICK_LEFT:  begin d.pins = PINS_SPIN_L;  d.duty_a = f; d.duty_b = f; end
            MODE_SOFT_LEFT:   begin d.pins = PINS_FORWARD; d.duty_a = s; d.duty_b = f; end
            MODE_QUICK_RIGHT: begin d.pins = PINS_SPIN_R;  d.duty_a = f; d.duty_b = f; end
            default:          begin d.pins = PINS_FORWARD; d.duty_a = f; d.duty_b = s; end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> src/uoas_echo.sv
`default_nettype none

module uoas_echo
    import uoas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  levels,
    input  wire logic [15:0] echo_timeout,
    output echo_stat_t       stat_next
);

    logic [2:0]                 prev_reg;
    logic [COUNT_BITS-1:0]      counter_reg;
    logic [COUNT_BITS-1:0]      counter_next;
    logic [2:0][COUNT_BITS-1:0] counts_reg;
    logic [2:0]                 invalid_reg;
    logic [2:0]                 fell;
    logic                       timed_out;

    assign fell      = prev_reg & ~levels;
    assign timed_out = counter_reg > COUNT_BITS'(echo_timeout);

    // A falling edge latches the count held before this tick.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fell[i])
            begin
                stat_next.counts[i]  = counter_reg;
                stat_next.invalid[i] = timed_out;
            end
            else
            begin
                stat_next.counts[i]  = counts_reg[i];
                stat_next.invalid[i] = invalid_reg[i];
            end
        end
    end

    always_comb
    begin
        if (levels[0] && !prev_reg[0])
            counter_next = '0;
        else if (counter_reg != '1)
            counter_next = counter_reg + COUNT_BITS'(1);
        else
            counter_next = counter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            counter_reg <= '0;
            counts_reg  <= '0;
            invalid_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg    <= levels;
            counter_reg <= counter_next;
            counts_reg  <= stat_next.counts;
            invalid_reg <= stat_next.invalid;
        end
    end

endmodule

`default_nettype wire

>>> src/uoas_seq.sv
`default_nettype none

module uoas_seq
    import uoas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire cfg_t       cfg,
    input  wire echo_stat_t echo,
    output drive_t          drive_next
);

    typedef enum logic [4:0] {
        PH_DECIDE  = 5'b00001,
        PH_STOP    = 5'b00010,
        PH_REVERSE = 5'b00100,
        PH_TURN    = 5'b01000,
        PH_SETTLE  = 5'b10000
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    drive_t                drive_reg;

    logic [TIMER_BITS-1:0] t_stop;
    logic [TIMER_BITS-1:0] t_reverse;
    logic [TIMER_BITS-1:0] t_turn;
    logic [TIMER_BITS-1:0] t_settle;
    logic [COUNT_BITS-1:0] th;
    logic [COUNT_BITS-1:0] cf;
    logic [COUNT_BITS-1:0] cr;
    logic [COUNT_BITS-1:0] cl;
    logic                  f_near;
    logic                  r_near;
    logic                  l_near;
    logic                  r_ranks_lower;
    logic                  r_ranks_higher;

    phase_t                dec_phase;
    logic [TIMER_BITS-1:0] dec_timer;
    drive_t                dec_drive;

    assign t_stop    = timer_sat(cfg.stop_time);
    assign t_reverse = timer_sat(cfg.reverse_time);
    assign t_turn    = timer_sat(cfg.turn_time);
    assign t_settle  = timer_sat(cfg.settle_time);

    assign th     = COUNT_BITS'(cfg.near_threshold);
    assign cf     = echo.counts[0];
    assign cr     = echo.counts[1];
    assign cl     = echo.counts[2];
    assign f_near = cf < th;
    assign r_near = cr < th;
    assign l_near = cl < th;

    // An invalid reading ranks below every valid count.
    always_comb
    begin
        if (echo.invalid[1] && echo.invalid[2])
        begin
            r_ranks_lower  = 1'b0;
            r_ranks_higher = 1'b0;
        end
        else if (echo.invalid[1] || echo.invalid[2])
        begin
            r_ranks_lower  = echo.invalid[1];
            r_ranks_higher = echo.invalid[2];
        end
        else
        begin
            r_ranks_lower  = cr < cl;
            r_ranks_higher = cr > cl;
        end
    end

    always_comb
    begin
        dec_drive = drive_reg;
        if (echo.invalid != 3'b000)
        begin
            dec_phase = PH_SETTLE;
            dec_timer = t_settle;
        end
        else if (f_near && r_near && l_near)
        begin
            dec_drive = apply_mode(drive_reg, MODE_STOP, cfg.fast_duty, cfg.slow_duty);
            dec_phase = PH_STOP;
            dec_timer = t_stop;
        end
        else if (r_near && (cr < cl))
        begin
            dec_drive = apply_mode(drive_reg, MODE_SOFT_LEFT, cfg.fast_duty, cfg.slow_duty);
            dec_phase = PH_TURN;
            dec_timer = t_turn;
        end
        else if (l_near && (cr > cl))
        begin
            dec_drive = apply_mode(drive_reg, MODE_SOFT_RIGHT, cfg.fast_duty, cfg.slow_duty);
            dec_phase = PH_TURN;
            dec_timer = t_turn;
        end
        else
        begin
            dec_drive = apply_mode(drive_reg, MODE_FORWARD, cfg.fast_duty, cfg.slow_duty);
            dec_phase = PH_SETTLE;
            dec_timer = t_settle;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        drive_next = drive_reg;
        if (phase_reg != PH_DECIDE && timer_reg > TIMER_BITS'(1))
        begin
            timer_next = timer_reg - TIMER_BITS'(1);
        end
        else
        begin
            case (phase_reg)
                PH_STOP:
                begin
                    drive_next = apply_mode(drive_reg, MODE_REVERSE,
                                            cfg.fast_duty, cfg.slow_duty);
                    phase_next = PH_REVERSE;
                    timer_next = t_reverse;
                end
                PH_REVERSE:
                begin
                    if (r_ranks_lower)
                    begin
                        drive_next = apply_mode(drive_reg, MODE_QUICK_LEFT,
                                                cfg.fast_duty, cfg.slow_duty);
                        phase_next = PH_TURN;
                        timer_next = t_turn;
                    end
                    else if (r_ranks_higher)
                    begin
                        drive_next = apply_mode(drive_reg, MODE_QUICK_RIGHT,
                                                cfg.fast_duty, cfg.slow_duty);
                        phase_next = PH_TURN;
                        timer_next = t_turn;
                    end
                    else
                    begin
                        phase_next = PH_SETTLE;
                        timer_next = t_settle;
                    end
                end
                PH_TURN:
                begin
                    phase_next = PH_SETTLE;
                    timer_next = t_settle;
                end
                default:
                begin
                    // Decide, and the end of a settle wait, pick the next maneuver.
                    drive_next = dec_drive;
                    phase_next = dec_phase;
                    timer_next = dec_timer;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_DECIDE;
            timer_reg        <= '0;
            drive_reg.pins   <= PINS_RESET;
            drive_reg.duty_a <= DUTY_RESET;
            drive_reg.duty_b <= DUTY_RESET;
            drive_reg.mode   <= MODE_NONE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            drive_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ultrasonic_obstacle_avoid_sequencer.sv
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the output register is refilled in the
// same cycle it is taken, so only a stalled master side holds off the slave side.
// Reset (rst_n low, asynchronous): echo state and timer cleared, sequencer at
// decide, drive pins 0, duties 333, mode none, configuration at its defaults.
`default_nettype none

module ultrasonic_obstacle_avoid_sequencer
    import uoas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // front_echo, right_echo, left_echo
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // dir_pins, duty_a, duty_b, drive_mode, front_count, right_count, left_count,
    // invalid_flags
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [23:0]            cfg_data
);

    cfg_t                   cfg_reg;
    logic                   accept;
    echo_stat_t             echo_next;
    drive_t                 drive_next;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= 16'd2353;
            cfg_reg.echo_timeout   <= 16'd60000;
            cfg_reg.stop_time      <= 24'd50000;
            cfg_reg.reverse_time   <= 24'd500000;
            cfg_reg.turn_time      <= 24'd800000;
            cfg_reg.settle_time    <= 24'd100000;
            cfg_reg.fast_duty      <= 10'd300;
            cfg_reg.slow_duty      <= 10'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NEAR_THRESHOLD: cfg_reg.near_threshold <= cfg_data[15:0];
                REG_ECHO_TIMEOUT:   cfg_reg.echo_timeout   <= cfg_data[15:0];
                REG_STOP_TIME:      cfg_reg.stop_time      <= cfg_data;
                REG_REVERSE_TIME:   cfg_reg.reverse_time   <= cfg_data;
                REG_TURN_TIME:      cfg_reg.turn_time      <= cfg_data;
                REG_SETTLE_TIME:    cfg_reg.settle_time    <= cfg_data;
                REG_FAST_DUTY:      cfg_reg.fast_duty      <= cfg_data[9:0];
                REG_SLOW_DUTY:      cfg_reg.slow_duty      <= cfg_data[9:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    uoas_echo u_echo (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .levels       (s_tdata[2:0]),
        .echo_timeout (cfg_reg.echo_timeout),
        .stat_next    (echo_next)
    );

    uoas_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cfg        (cfg_reg),
        .echo       (echo_next),
        .drive_next (drive_next)
    );

    assign m_tdata_next = {2'b00,
                           echo_next.invalid,
                           count_disp(echo_next.counts[2]),
                           count_disp(echo_next.counts[1]),
                           count_disp(echo_next.counts[0]),
                           drive_next.mode,
                           drive_next.duty_b,
                           drive_next.duty_a,
                           drive_next.pins};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

>>> src/uoas_checker.sv
`default_nettype none

module uoas_checker
    import uoas_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [2:0]             cfg_index,
    input wire logic [23:0]            cfg_data
);

    // Every accepted word yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word produced no result");

    a_master_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[13:4] <= DUTY_MAX) && (m_tdata[23:14] <= DUTY_MAX)))
        else $error("duty above 999");

    a_stop_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[26:24] == MODE_STOP)) |-> (m_tdata[3:0] == PINS_BRAKE))
        else $error("stop mode without brake pins");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[79:78] == 2'b00))
        else $error("result padding not zero");

endmodule

bind ultrasonic_obstacle_avoid_sequencer uoas_checker u_uoas_checker (.*);

`default_nettype wire

>>> tb/uoas_drive_monitor.sv
module uoas_drive_monitor
    import uoas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [23:0]            cfg_data,
    output int                          mismatches,
    output int                          outstanding
);

    typedef enum logic [2:0] {
        SEQ_DECIDE,
        SEQ_STOP,
        SEQ_REVERSE,
        SEQ_TURN,
        SEQ_SETTLE
    } seq_phase_t;

    // Output word layout, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]  invalid;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] front;
        logic [2:0]  mode;
        logic [9:0]  duty_b;
        logic [9:0]  duty_a;
        logic [3:0]  pins;
    } drive_word_t;

    cfg_t                  regs;
    logic [2:0]            lv_prev;
    logic [COUNT_BITS-1:0] echo_cnt;
    logic [COUNT_BITS-1:0] latched [3];
    logic [2:0]            timed_out;
    seq_phase_t            seq;
    logic [TIMER_BITS-1:0] seq_timer;
    drive_t                drive;
    drive_word_t           drive_due [$];

    function automatic drive_t motor_table(input drive_t cur, input logic [2:0] m);
        drive_t     nxt;
        logic [9:0] full;
        logic [9:0] slow;
        full     = (regs.fast_duty > DUTY_MAX) ? DUTY_MAX : regs.fast_duty;
        slow     = (regs.slow_duty > DUTY_MAX) ? DUTY_MAX : regs.slow_duty;
        nxt      = cur;
        nxt.mode = m;
        if (m == MODE_STOP)
        begin
            // Braking leaves the duties where they were.
            nxt.pins = PINS_BRAKE;
            return nxt;
        end
        nxt.pins   = PINS_FORWARD;
        nxt.duty_a = full;
        nxt.duty_b = full;
        case (m)
            MODE_REVERSE:     nxt.pins = PINS_REVERSE;
            MODE_QUICK_LEFT:  nxt.pins = PINS_SPIN_L;
            MODE_QUICK_RIGHT: nxt.pins = PINS_SPIN_R;
            MODE_SOFT_LEFT:   nxt.duty_a = slow;
            MODE_SOFT_RIGHT:  nxt.duty_b = slow;
            default:          ;
        endcase
        return nxt;
    endfunction

    function automatic void enter_phase(input seq_phase_t p, input logic [23:0] dur);
        seq       = p;
        seq_timer = TIMER_BITS'(dur);
    endfunction

    function automatic void choose_manoeuvre();
        logic [15:0] th;
        logic [15:0] f;
        logic [15:0] r;
        logic [15:0] l;
        th = regs.near_threshold;
        f  = latched[0];
        r  = latched[1];
        l  = latched[2];
        if (timed_out != 3'b000)
            enter_phase(SEQ_SETTLE, regs.settle_time);
        else if (f < th && r < th && l < th)
        begin
            drive = motor_table(drive, MODE_STOP);
            enter_phase(SEQ_STOP, regs.stop_time);
        end
        else if (r < th && r < l)
        begin
            drive = motor_table(drive, MODE_SOFT_LEFT);
            enter_phase(SEQ_TURN, regs.turn_time);
        end
        else if (l < th && r > l)
        begin
            drive = motor_table(drive, MODE_SOFT_RIGHT);
            enter_phase(SEQ_TURN, regs.turn_time);
        end
        else
        begin
            drive = motor_table(drive, MODE_FORWARD);
            enter_phase(SEQ_SETTLE, regs.settle_time);
        end
    endfunction

    // A timed-out side ranks below any valid distance.
    function automatic int side_rank(input int i);
        return timed_out[i] ? -1 : int'(latched[i]);
    endfunction

    function automatic void finish_reverse();
        int kr;
        int kl;
        kr = side_rank(1);
        kl = side_rank(2);
        if (kr < kl)
        begin
            drive = motor_table(drive, MODE_QUICK_LEFT);
            enter_phase(SEQ_TURN, regs.turn_time);
        end
        else if (kr > kl)
        begin
            drive = motor_table(drive, MODE_QUICK_RIGHT);
            enter_phase(SEQ_TURN, regs.turn_time);
        end
        else
            enter_phase(SEQ_SETTLE, regs.settle_time);
    endfunction

    function automatic drive_word_t advance_sequencer(input logic [2:0] lv);
        logic [2:0]  fell;
        drive_word_t w;
        fell = lv_prev & ~lv;
        // Falling edges latch the count held before this tick.
        for (int i = 0; i < 3; i++)
        begin
            if (fell[i])
            begin
                latched[i]   = echo_cnt;
                timed_out[i] = (echo_cnt > regs.echo_timeout);
            end
        end
        if (lv[0] && !lv_prev[0])
            echo_cnt = '0;
        else if (echo_cnt != '1)
            echo_cnt = echo_cnt + 1'b1;
        lv_prev = lv;

        if (seq == SEQ_DECIDE)
            choose_manoeuvre();
        else if (seq_timer > 1)
            seq_timer = seq_timer - 1'b1;
        else
        begin
            case (seq)
                SEQ_STOP:
                begin
                    drive = motor_table(drive, MODE_REVERSE);
                    enter_phase(SEQ_REVERSE, regs.reverse_time);
                end
                SEQ_REVERSE: finish_reverse();
                SEQ_TURN:    enter_phase(SEQ_SETTLE, regs.settle_time);
                default:     choose_manoeuvre();
            endcase
        end

        w.pins    = drive.pins;
        w.duty_a  = drive.duty_a;
        w.duty_b  = drive.duty_b;
        w.mode    = drive.mode;
        w.front   = 16'(latched[0]);
        w.right   = 16'(latched[1]);
        w.left    = 16'(latched[2]);
        w.invalid = timed_out;
        return w;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t got;
        drive_word_t want;
        if (!rst_n)
        begin
            regs.near_threshold = 16'd2353;
            regs.echo_timeout   = 16'd60000;
            regs.stop_time      = 24'd50000;
            regs.reverse_time   = 24'd500000;
            regs.turn_time      = 24'd800000;
            regs.settle_time    = 24'd100000;
            regs.fast_duty      = 10'd300;
            regs.slow_duty      = 10'd100;
            lv_prev             = '0;
            echo_cnt            = '0;
            for (int i = 0; i < 3; i++)
                latched[i] = '0;
            timed_out           = '0;
            seq                 = SEQ_DECIDE;
            seq_timer           = '0;
            drive.pins          = PINS_RESET;
            drive.duty_a        = DUTY_RESET;
            drive.duty_b        = DUTY_RESET;
            drive.mode          = MODE_NONE;
            drive_due.delete();
            outstanding         = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = drive_word_t'(m_tdata[$bits(drive_word_t)-1:0]);
                if (drive_due.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = drive_due.pop_front();
                    check_field("dir_pins", want.pins, got.pins);
                    check_field("duty_a", want.duty_a, got.duty_a);
                    check_field("duty_b", want.duty_b, got.duty_b);
                    check_field("drive_mode", want.mode, got.mode);
                    check_field("front_count", want.front, got.front);
                    check_field("right_count", want.right, got.right);
                    check_field("left_count", want.left, got.left);
                    check_field("invalid_flags", want.invalid, got.invalid);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NEAR_THRESHOLD: regs.near_threshold = cfg_data[15:0];
                    REG_ECHO_TIMEOUT:   regs.echo_timeout   = cfg_data[15:0];
                    REG_STOP_TIME:      regs.stop_time      = cfg_data;
                    REG_REVERSE_TIME:   regs.reverse_time   = cfg_data;
                    REG_TURN_TIME:      regs.turn_time      = cfg_data;
                    REG_SETTLE_TIME:    regs.settle_time    = cfg_data;
                    REG_FAST_DUTY:      regs.fast_duty      = cfg_data[9:0];
                    REG_SLOW_DUTY:      regs.slow_duty      = cfg_data[9:0];
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_due.push_back(advance_sequencer(s_tdata[2:0]));
            outstanding = drive_due.size();
        end
    end

endmodule

>>> tb/ultrasonic_obstacle_avoid_sequencer_tb.sv
module ultrasonic_obstacle_avoid_sequencer_tb;
    import uoas_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [2:0]             cfg_index;
    logic [23:0]            cfg_data;
    int                     mismatches;
    int                     outstanding;

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_request;
    int ticks_sent;

    ultrasonic_obstacle_avoid_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uoas_drive_monitor drive_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off when asked for.
    initial
    begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_seen)
                hold_left = 80;
            hold_seen = hold_request;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // All tasks start and end on a falling edge.
    task automatic push_levels(input logic [2:0] lv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, lv};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [15:0] near, input logic [15:0] timeout,
                                 input logic [23:0] stop_t, input logic [23:0] rev_t,
                                 input logic [23:0] turn_t, input logic [23:0] settle_t,
                                 input logic [9:0] fast, input logic [9:0] slow);
        wait_drained();
        write_reg(REG_NEAR_THRESHOLD, 24'(near));
        write_reg(REG_ECHO_TIMEOUT, 24'(timeout));
        write_reg(REG_STOP_TIME, stop_t);
        write_reg(REG_REVERSE_TIME, rev_t);
        write_reg(REG_TURN_TIME, turn_t);
        write_reg(REG_SETTLE_TIME, settle_t);
        write_reg(REG_FAST_DUTY, 24'(fast));
        write_reg(REG_SLOW_DUTY, 24'(slow));
        cfg_valid <= 1'b0;
    endtask

    // One measurement: the front echo rises to restart the count unless drawn with zero
    // width, the three echoes stay high for random widths, then the lines rest.
    task automatic send_ping(input int width_max);
        int         rise [3];
        int         width [3];
        int         span;
        logic [2:0] lv;
        span = 0;
        for (int i = 0; i < 3; i++)
        begin
            rise[i]  = (i == 0) ? (($urandom_range(9) == 0) ? 1 : 0) : $urandom_range(0, 3);
            width[i] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, width_max);
            if (rise[i] + width[i] > span)
                span = rise[i] + width[i];
        end
        for (int t = 0; t <= span; t++)
        begin
            for (int i = 0; i < 3; i++)
                lv[i] = (t >= rise[i]) && (t < rise[i] + width[i]);
            push_levels(lv);
        end
        repeat ($urandom_range(1, 10))
            push_levels(3'b000);
    endtask

    task automatic run_pings(input int n, input int width_max);
        int target;
        target = ticks_sent + n;
        while (ticks_sent < target)
        begin
            if ($urandom_range(99) < 80)
                send_ping(width_max);
            else
                repeat ($urandom_range(1, 8))
                    push_levels(3'($urandom_range(7)));
        end
    endtask

    initial
    begin
        logic [2:0] opening [25];
        logic [15:0] near;
        logic [15:0] timeout;
        opening = '{3'b000, 3'b111, 3'b111, 3'b110, 3'b100, 3'b101, 3'b100, 3'b100,
                    3'b100, 3'b100, 3'b100, 3'b100, 3'b100, 3'b000, 3'b011, 3'b010,
                    3'b000, 3'b001, 3'b111, 3'b000, 3'b010, 3'b110, 3'b000, 3'b100,
                    3'b000};
        src_idle_pct  = 23;
        sink_idle_pct = 23;
        hold_request  = 1'b0;
        ticks_sent    = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_NEAR_THRESHOLD;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short timings so the whole stop, reverse, turn, settle loop turns over.
        load_settings(16'd4, 16'd6, 24'd1, 24'd2, 24'd1, 24'd0, 10'd999, 10'd100);
        foreach (opening[k])
            push_levels(opening[k]);

        load_settings(16'd20, 16'd45, 24'd3, 24'd5, 24'd4, 24'd2, 10'd300, 10'd100);
        run_pings(250, 60);
        hold_request = 1'b1;
        run_pings(250, 60);
        wait_drained();
        run_pings(150, 60);

        // Every count below 65535 counts as near and no reading can time out.
        load_settings(16'hFFFF, 16'hFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 10'd1023, 10'd0);
        run_pings(200, 30);

        // Nothing is near; any nonzero count times out.
        load_settings(16'd0, 16'd0, 24'd2, 24'd2, 24'd2, 24'd1, 10'd0, 10'd999);
        run_pings(150, 4);

        repeat (4)
        begin
            near    = 16'($urandom_range(2, 40));
            timeout = near + 16'($urandom_range(0, 40));
            load_settings(near, timeout, 24'($urandom_range(0, 8)), 24'($urandom_range(0, 8)),
                          24'($urandom_range(0, 8)), 24'($urandom_range(0, 8)),
                          10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            run_pings(120, int'(timeout) + 15);
        end

        // No idling here: one long right echo, then plain pings.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_settings(16'd30, 16'd65534, 24'd2, 24'd3, 24'd2, 24'd1, 10'd500, 10'd250);
        push_levels(3'b000);
        repeat (150)
            push_levels(3'b010);
        push_levels(3'b000);
        run_pings(200, 60);
        src_idle_pct  = 23;
        sink_idle_pct = 23;

        load_settings(16'd1000, 16'd2000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      10'd512, 10'd1023);
        run_pings(150, 120);

        wait_drained();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
